[rtl/core/srf_pkg.sv]
`default_nettype none

package srf_pkg;

    // longest record body: address bytes plus data bytes
    localparam int MAX_RECORD_BYTES = 36;
    localparam int FILL_W = $clog2(MAX_RECORD_BYTES + 1);
    localparam int IDX_W = $clog2(MAX_RECORD_BYTES);

    // fixed records
    localparam int HDR_LEN = 5;
    localparam int TRL_LEN = 4;

    // record type digits
    localparam logic [3:0] REC_HDR = 4'd0;
    localparam logic [3:0] REC_TRM = 4'd9;

    typedef enum logic [1:0] {
        REQ_DATA   = 2'd0,
        REQ_START  = 2'd1,
        REQ_FINISH = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAD,
        ST_FIX,
        ST_FL_COUNT,
        ST_FL_DATA,
        ST_FL_SUM,
        ST_AP_ADDR,
        ST_AP_DATA
    } state_t;

    // one output byte with its side flags
    typedef struct packed {
        logic [3:0] rtype;
        logic [7:0] rbyte;
        logic       first;
        logic       rend;
        logic       bad;
        logic       last;
    } res_t;

    // bytes of the S0 header and the S9 terminator
    function automatic logic [7:0] fixed_byte(input logic hdr, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (hdr)
        begin
            case (idx)
                3'd0:    b = 8'h04;
                3'd3:    b = 8'h20;
                3'd4:    b = 8'hDB;
                default: b = 8'h00;
            endcase
        end
        else
        begin
            case (idx)
                3'd0:    b = 8'h03;
                3'd3:    b = 8'hFC;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

    // S-type for a start address: 1, 2 or 3 (address bytes = type + 1)
    function automatic logic [1:0] addr_kind(input logic [31:0] a);
        logic [1:0] k;
        if (a[31:16] == 16'h0000)
            k = 2'd1;
        else if (a[31:24] == 8'h00)
            k = 2'd2;
        else
            k = 2'd3;
        return k;
    endfunction

    // byte k of a word, byte 0 lowest
    function automatic logic [7:0] byte_sel(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = w[7:0];
            2'd1:    b = w[15:8];
            2'd2:    b = w[23:16];
            2'd3:    b = w[31:24];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[rtl/core/srf_ram.sv]
`default_nettype none

module srf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 36
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/srf_obuf.sv]
`default_nettype none

module srf_obuf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire srf_pkg::res_t in_res,
    output logic               out_valid,
    input  wire logic          out_ready,
    output srf_pkg::res_t      out_res
);

    srf_pkg::res_t ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = ent_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= in_res;
    end

endmodule

`default_nettype wire

[rtl/core/srf_ctrl.sv]
`default_nettype none

module srf_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // request transaction
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 in_req,
    input  wire logic [31:0]                in_addr,
    input  wire logic [31:0]                in_data,
    input  wire logic [2:0]                 in_size,
    // result towards the output buffer
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output srf_pkg::res_t                   res,
    // record buffer memory
    output logic                            wr_en,
    output logic [srf_pkg::IDX_W-1:0]       wr_addr,
    output logic [7:0]                      wr_data,
    output logic                            rd_en,
    output logic [srf_pkg::IDX_W-1:0]       rd_addr,
    input  wire logic [7:0]                 rd_data
);

    localparam int FW = srf_pkg::FILL_W;

    srf_pkg::state_t state_reg, state_next;
    srf_pkg::req_t   req_reg, req_next;
    srf_pkg::req_t   in_req_t;
    logic [31:0]     addr_reg, addr_next;
    logic [31:0]     data_reg, data_next;
    logic [2:0]      size_reg, size_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [7:0]      sum_reg, sum_next;
    logic            open_reg, open_next;
    logic [31:0]     naddr_reg, naddr_next;
    logic [1:0]      otype_reg, otype_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [srf_pkg::IDX_W-1:0] idx_reg, idx_next;

    logic            size_ok;
    logic            over;
    logic            need_flush;
    logic [FW:0]     fill_plus;
    logic [FW-1:0]   idx_inc;
    logic [7:0]      count_byte;
    logic [1:0]      in_kind;
    logic [1:0]      reg_kind;
    logic            fix_hdr;
    logic            fix_end;

    assign in_req_t = srf_pkg::req_t'(in_req);
    assign in_ready = (state_reg == srf_pkg::ST_IDLE);

    // decisions on the incoming item
    assign size_ok    = (in_size == 3'd1) || (in_size == 3'd2) || (in_size == 3'd4);
    assign fill_plus  = (FW + 1)'(fill_reg) + (FW + 1)'(in_size);
    assign over       = (fill_plus > (FW + 1)'(srf_pkg::MAX_RECORD_BYTES));
    assign need_flush = open_reg && ((in_addr != naddr_reg) || over);
    assign in_kind    = srf_pkg::addr_kind(in_addr);
    assign reg_kind   = srf_pkg::addr_kind(addr_reg);

    // flush helpers
    assign idx_inc    = FW'(idx_reg) + FW'(1);
    assign count_byte = 8'(fill_reg) + 8'd1;

    // fixed record helpers
    assign fix_hdr = (req_reg == srf_pkg::REQ_START);
    assign fix_end = fix_hdr ? (cnt_reg == 3'(srf_pkg::HDR_LEN - 1))
                             : (cnt_reg == 3'(srf_pkg::TRL_LEN - 1));

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        size_next  = size_reg;
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        open_next  = open_reg;
        naddr_next = naddr_reg;
        otype_next = otype_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        res_valid  = 1'b0;
        res        = '0;
        wr_en      = 1'b0;
        wr_addr    = fill_reg[srf_pkg::IDX_W-1:0];
        wr_data    = 8'h00;
        rd_en      = 1'b0;
        rd_addr    = '0;

        case (state_reg)
            srf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next  = in_req_t;
                    addr_next = in_addr;
                    data_next = in_data;
                    size_next = in_size;
                    case (in_req_t)
                        srf_pkg::REQ_DATA:
                        begin
                            if (!size_ok)
                                state_next = srf_pkg::ST_BAD;
                            else if (need_flush)
                                state_next = srf_pkg::ST_FL_COUNT;
                            else if (!open_reg)
                            begin
                                otype_next = in_kind;
                                cnt_next   = {1'b0, in_kind};
                                fill_next  = '0;
                                sum_next   = 8'h00;
                                state_next = srf_pkg::ST_AP_ADDR;
                            end
                            else
                            begin
                                cnt_next   = in_size - 3'd1;
                                state_next = srf_pkg::ST_AP_DATA;
                            end
                        end
                        srf_pkg::REQ_START:
                        begin
                            open_next  = 1'b0;
                            fill_next  = '0;
                            sum_next   = 8'h00;
                            cnt_next   = 3'd0;
                            state_next = srf_pkg::ST_FIX;
                        end
                        srf_pkg::REQ_FINISH:
                        begin
                            cnt_next   = 3'd0;
                            state_next = open_reg ? srf_pkg::ST_FL_COUNT : srf_pkg::ST_FIX;
                        end
                        default:
                        begin
                            state_next = srf_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // dropped item: one flagged result
            srf_pkg::ST_BAD:
            begin
                res_valid = 1'b1;
                res.bad   = 1'b1;
                res.last  = 1'b1;
                if (res_ready)
                    state_next = srf_pkg::ST_IDLE;
            end

            // header or terminator bytes from the table
            srf_pkg::ST_FIX:
            begin
                res_valid = 1'b1;
                res.rtype = fix_hdr ? srf_pkg::REC_HDR : srf_pkg::REC_TRM;
                res.rbyte = srf_pkg::fixed_byte(fix_hdr, cnt_reg);
                res.first = (cnt_reg == 3'd0);
                res.rend  = fix_end;
                res.last  = fix_end;
                if (res_ready)
                begin
                    if (fix_end)
                        state_next = srf_pkg::ST_IDLE;
                    else
                        cnt_next = cnt_reg + 3'd1;
                end
            end

            // count byte, first buffer read issued alongside
            srf_pkg::ST_FL_COUNT:
            begin
                res_valid = 1'b1;
                res.rtype = {2'b00, otype_reg};
                res.rbyte = count_byte;
                res.first = 1'b1;
                if (res_ready)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    idx_next   = '0;
                    state_next = srf_pkg::ST_FL_DATA;
                end
            end

            // buffered bytes; memory output holds while stalled
            srf_pkg::ST_FL_DATA:
            begin
                res_valid = 1'b1;
                res.rtype = {2'b00, otype_reg};
                res.rbyte = rd_data;
                if (res_ready)
                begin
                    if (idx_inc < fill_reg)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc[srf_pkg::IDX_W-1:0];
                        idx_next = idx_inc[srf_pkg::IDX_W-1:0];
                    end
                    else
                        state_next = srf_pkg::ST_FL_SUM;
                end
            end

            // checksum closes the record
            srf_pkg::ST_FL_SUM:
            begin
                res_valid = 1'b1;
                res.rtype = {2'b00, otype_reg};
                res.rbyte = ~(sum_reg + count_byte);
                res.rend  = 1'b1;
                res.last  = (req_reg == srf_pkg::REQ_DATA);
                if (res_ready)
                begin
                    open_next = 1'b0;
                    fill_next = '0;
                    sum_next  = 8'h00;
                    if (req_reg == srf_pkg::REQ_DATA)
                    begin
                        otype_next = reg_kind;
                        cnt_next   = {1'b0, reg_kind};
                        state_next = srf_pkg::ST_AP_ADDR;
                    end
                    else
                    begin
                        cnt_next   = 3'd0;
                        state_next = srf_pkg::ST_FIX;
                    end
                end
            end

            // address bytes of a new record, most significant first
            srf_pkg::ST_AP_ADDR:
            begin
                wr_en     = 1'b1;
                wr_data   = srf_pkg::byte_sel(addr_reg, cnt_reg[1:0]);
                fill_next = fill_reg + FW'(1);
                sum_next  = sum_reg + wr_data;
                if (cnt_reg == 3'd0)
                begin
                    cnt_next   = size_reg - 3'd1;
                    state_next = srf_pkg::ST_AP_DATA;
                end
                else
                    cnt_next = cnt_reg - 3'd1;
            end

            // data bytes, most significant first
            srf_pkg::ST_AP_DATA:
            begin
                wr_en     = 1'b1;
                wr_data   = srf_pkg::byte_sel(data_reg, cnt_reg[1:0]);
                fill_next = fill_reg + FW'(1);
                sum_next  = sum_reg + wr_data;
                if (cnt_reg == 3'd0)
                begin
                    open_next  = 1'b1;
                    naddr_next = addr_reg + 32'(size_reg);
                    state_next = srf_pkg::ST_IDLE;
                end
                else
                    cnt_next = cnt_reg - 3'd1;
            end

            default:
            begin
                state_next = srf_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srf_pkg::ST_IDLE;
            fill_reg  <= '0;
            sum_reg   <= 8'h00;
            open_reg  <= 1'b0;
            naddr_reg <= 32'h0;
            otype_reg <= 2'd0;
            cnt_reg   <= 3'd0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
            open_reg  <= open_next;
            naddr_reg <= naddr_next;
            otype_reg <= otype_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    // latched request payload
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        addr_reg <= addr_next;
        data_reg <= data_next;
        size_reg <= size_next;
    end

endmodule

`default_nettype wire

[rtl/core/srecord_framer.sv]
// A request's first result byte passes the control state register, then the output buffer register.
// Intake: a data item holds the intake while its buffered bytes are written
// (size, plus 2 to 4 address bytes when it opens a record); one write port, one byte a cycle.
// A flush holds it longer (one buffer read per byte), as do the header and terminator records.
// Reset: rst_n is asynchronous, active low; clears control state, no record open.
// Record buffer contents are undefined after reset; no clearing pass is run.
`default_nettype none

module srecord_framer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // address [31:0], data_value [63:32], size_bytes [66:64], zero pad [71:67]
    input  wire logic [71:0] s_tdata,
    // req_type [1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // record_byte [7:0]
    output logic [7:0]       m_tdata,
    // record_type [3:0], record_first [4], record_end [5], bad_size [6]
    output logic [6:0]       m_tuser,
    // run_last
    output logic             m_tlast
);

    logic                      res_valid;
    logic                      res_ready;
    srf_pkg::res_t             res;
    srf_pkg::res_t             out_res;
    logic                      wr_en;
    logic [srf_pkg::IDX_W-1:0] wr_addr;
    logic [7:0]                wr_data;
    logic                      rd_en;
    logic [srf_pkg::IDX_W-1:0] rd_addr;
    logic [7:0]                rd_data;

    // sequencer
    srf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .in_addr   (s_tdata[31:0]),
        .in_data   (s_tdata[63:32]),
        .in_size   (s_tdata[66:64]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // record buffer
    srf_ram #(
        .WIDTH (8),
        .DEPTH (srf_pkg::MAX_RECORD_BYTES)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output stage
    srf_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.rbyte;
    assign m_tuser = {out_res.bad, out_res.rend, out_res.first, out_res.rtype};
    assign m_tlast = out_res.last;

    // no result is produced while a new transaction can be taken
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !res_valid)
        else $error("result produced while idle");

    // buffer is never written and read in the same cycle
    a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !rd_en)
        else $error("record buffer write and read overlap");

    // a dropped item ends its run
    a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[6]) |-> m_tlast)
        else $error("bad size result not marked last");

    // terminator checksum ends its run
    a_trm_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[5] && (m_tuser[3:0] == srf_pkg::REC_TRM)) |-> m_tlast)
        else $error("terminator end not marked last");

endmodule

`default_nettype wire
